// File: hdl/assert_macros.svh
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FFA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define FFA_ASSERT(lbl, prop, msg) \
  `FFA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/ffa_pkg.sv
package ffa_pkg;

  localparam int MAX_REQUESTS = 1024;
  localparam int MAX_SEGMENTS = 1024;
  localparam int ADDR_BITS    = 21;

  localparam int SEG_IW = $clog2(MAX_SEGMENTS);
  localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
  localparam int REQ_IW = $clog2(MAX_REQUESTS);
  localparam int REQ_CW = $clog2(MAX_REQUESTS + 1);

  localparam int OP_W      = 2;
  localparam int REQ_NUM_W = 11;
  localparam int STATUS_W  = 2;
  localparam int SEG_W     = 2 * ADDR_BITS;
  localparam int GNT_W     = 2 * ADDR_BITS + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_INIT,
    DP_START,
    DP_SCAN_A,
    DP_ALLOC_FIN,
    DP_SHIFT_DN,
    DP_SHIFT_UP,
    DP_INSERT,
    DP_GRANT,
    DP_SCAN_F,
    DP_MERGE,
    DP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SCAN,
    S_A_FIN,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_INSERT,
    S_F_GRANT,
    S_F_SCAN,
    S_F_MERGE,
    S_RESP
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    opcode_e in_op;
    logic    req_full;
    logic    a_hit;
    logic    a_fail;
    logic    split;
    logic    free_ok;
    logic    f_end;
    logic    join_prev;
    logic    join_next;
    logic    seg_full;
    logic    dn_end;
    logic    up_end;
    logic    out_free;
    logic    is_alloc;
  } sts_t;

endpackage

// File: hdl/ffa_req_if.sv
interface ffa_req_if import ffa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [ADDR_BITS-1:0] alloc_length;
  logic [REQ_NUM_W-1:0] request_number;

  modport source (output valid, output opcode, output alloc_length,
                  output request_number, input ready);
  modport sink   (input valid, input opcode, input alloc_length,
                  input request_number, output ready);
endinterface

// File: hdl/ffa_rsp_if.sv
interface ffa_rsp_if import ffa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] block_start;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, output block_start, output status, input ready);
  modport sink   (input valid, input block_start, input status, output ready);
endinterface

// File: hdl/ffa_cfg_if.sv
interface ffa_cfg_if import ffa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] memory_size;

  modport source (output valid, output memory_size, input ready);
  modport sink   (input valid, input memory_size, output ready);
endinterface

// File: hdl/ffa_ram.sv
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/ffa_ctrl.sv
module ffa_ctrl import ffa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i && (sts_i.in_op == OP_ALLOC || sts_i.in_op == OP_FREE)) begin
          if (sts_i.req_full) begin
            state_d = S_RESP;
          end else if (sts_i.in_op == OP_ALLOC) begin
            state_d = S_A_SCAN;
          end else begin
            state_d = S_F_GRANT;
          end
        end
      end
      S_A_SCAN: begin
        if (sts_i.a_fail) begin
          state_d = S_RESP;
        end else if (sts_i.a_hit) begin
          state_d = S_A_FIN;
        end
      end
      S_A_FIN:    state_d = sts_i.split ? S_RESP : S_SHIFT_DN;
      S_SHIFT_DN: begin
        if (sts_i.dn_end) begin
          state_d = sts_i.is_alloc ? S_RESP : S_IDLE;
        end
      end
      S_SHIFT_UP: begin
        if (sts_i.up_end) begin
          state_d = S_INSERT;
        end
      end
      S_INSERT:   state_d = S_IDLE;
      S_F_GRANT:  state_d = sts_i.free_ok ? S_F_SCAN : S_IDLE;
      S_F_SCAN: begin
        if (sts_i.f_end) begin
          state_d = S_F_MERGE;
        end
      end
      S_F_MERGE: begin
        if (sts_i.join_prev && sts_i.join_next) begin
          state_d = S_SHIFT_DN;
        end else if (sts_i.join_prev || sts_i.join_next) begin
          state_d = S_IDLE;
        end else if (sts_i.seg_full) begin
          state_d = S_RESP;
        end else begin
          state_d = S_SHIFT_UP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o.op    = DP_NOP;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          case (sts_i.in_op)
            OP_INIT:  cmd_o.op = DP_INIT;
            OP_ALLOC: cmd_o.op = DP_START;
            OP_FREE:  cmd_o.op = DP_START;
            default:  cmd_o.op = DP_NOP;
          endcase
        end
      end
      S_A_SCAN:   cmd_o.op = DP_SCAN_A;
      S_A_FIN:    cmd_o.op = DP_ALLOC_FIN;
      S_SHIFT_DN: cmd_o.op = DP_SHIFT_DN;
      S_SHIFT_UP: cmd_o.op = DP_SHIFT_UP;
      S_INSERT:   cmd_o.op = DP_INSERT;
      S_F_GRANT:  cmd_o.op = DP_GRANT;
      S_F_SCAN:   cmd_o.op = DP_SCAN_F;
      S_F_MERGE:  cmd_o.op = DP_MERGE;
      S_RESP:     cmd_o.op = sts_i.out_free ? DP_EMIT : DP_NOP;
      default:    cmd_o.op = DP_NOP;
    endcase
  end

endmodule

// File: hdl/ffa_dp.sv
`include "assert_macros.svh"

module ffa_dp import ffa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [OP_W-1:0]      req_opcode_i,
  input  logic [ADDR_BITS-1:0] req_alloc_length_i,
  input  logic [REQ_NUM_W-1:0] req_request_number_i,
  ffa_cfg_if.sink              cfg,
  ffa_rsp_if.source            rsp
);

  localparam int A = ADDR_BITS;

  logic [A-1:0]         mem_size_q, mem_size_d;
  logic [SEG_CW-1:0]    seg_cnt_q, seg_cnt_d;
  logic [REQ_CW-1:0]    req_cnt_q, req_cnt_d;
  logic                 rv_q, rv_d;
  logic                 ov_q, ov_d;

  opcode_e              op_q, op_d;
  logic [A-1:0]         len_q, len_d;
  logic [REQ_NUM_W-1:0] req_q, req_d;
  logic [REQ_IW-1:0]    num_q, num_d;
  logic [SEG_CW-1:0]    k_q, k_d;
  logic [SEG_CW-1:0]    ri_q, ri_d;
  logic [SEG_CW-1:0]    p_q, p_d;
  logic [A-1:0]         gs_q, gs_d, gl_q, gl_d;
  logic [A-1:0]         ps_q, ps_d, pl_q, pl_d;
  logic [A-1:0]         ns_q, ns_d, nl_q, nl_d;
  logic                 hp_q, hp_d, hn_q, hn_d;
  logic [A-1:0]         res_b_q, res_b_d;
  status_e              res_s_q, res_s_d;
  logic [A-1:0]         ob_q, ob_d;
  status_e              os_q, os_d;

  logic                 seg_we;
  logic [SEG_IW-1:0]    seg_wa, seg_ra;
  logic [SEG_W-1:0]     seg_wd, seg_rd;
  logic                 gnt_we;
  logic [REQ_IW-1:0]    gnt_wa, gnt_ra;
  logic [GNT_W-1:0]     gnt_wd, gnt_rd;

  logic [A-1:0]         rd_s, rd_l, prev_end, gnt_end;
  logic [SEG_CW-1:0]    k_m1, ri_m1, ri_p1, p_m1;
  logic [REQ_NUM_W-1:0] req_m1, in_req_m1;
  logic                 f_stop;

  ffa_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (seg_wa),
    .wdata_i (seg_wd),
    .raddr_i (seg_ra),
    .rdata_o (seg_rd)
  );

  ffa_ram #(.WIDTH(GNT_W), .DEPTH(MAX_REQUESTS)) u_gnt_ram (
    .clk_i   (clk_i),
    .we_i    (gnt_we),
    .waddr_i (gnt_wa),
    .wdata_i (gnt_wd),
    .raddr_i (gnt_ra),
    .rdata_o (gnt_rd)
  );

  assign rd_s      = seg_rd[SEG_W-1:A];
  assign rd_l      = seg_rd[A-1:0];
  assign prev_end  = ps_q + pl_q;
  assign gnt_end   = gs_q + gl_q;
  assign k_m1      = k_q - 1'b1;
  assign ri_m1     = ri_q - 1'b1;
  assign ri_p1     = ri_q + 1'b1;
  assign p_m1      = p_q - 1'b1;
  assign req_m1    = req_q - 1'b1;
  assign in_req_m1 = req_request_number_i - 1'b1;
  assign f_stop    = rv_q && (rd_s > gs_q);

  always_comb begin
    sts_o.in_op     = opcode_e'(req_opcode_i);
    sts_o.req_full  = req_cnt_q >= REQ_CW'(MAX_REQUESTS);
    sts_o.a_hit     = rv_q && (len_q != '0) && (rd_l >= len_q);
    sts_o.a_fail    = (len_q == '0) || (!sts_o.a_hit && (k_q >= seg_cnt_q));
    sts_o.split     = nl_q > len_q;
    sts_o.free_ok   = (req_q != '0) && (32'(req_q) < 32'(req_cnt_q)) && gnt_rd[GNT_W-1];
    sts_o.f_end     = f_stop || (k_q >= seg_cnt_q);
    sts_o.join_prev = hp_q && (prev_end == gs_q);
    sts_o.join_next = hn_q && (gnt_end == ns_q);
    sts_o.seg_full  = seg_cnt_q >= SEG_CW'(MAX_SEGMENTS);
    sts_o.dn_end    = k_q >= seg_cnt_q;
    sts_o.up_end    = k_q <= p_q;
    sts_o.out_free  = !ov_q || rsp.ready;
    sts_o.is_alloc  = op_q == OP_ALLOC;
  end

  always_comb begin
    mem_size_d = cfg.valid ? cfg.memory_size : mem_size_q;
    seg_cnt_d  = seg_cnt_q;
    req_cnt_d  = req_cnt_q;
    rv_d       = rv_q;
    ov_d       = (ov_q && rsp.ready) ? 1'b0 : ov_q;
    op_d       = op_q;
    len_d      = len_q;
    req_d      = req_q;
    num_d      = num_q;
    k_d        = k_q;
    ri_d       = ri_q;
    p_d        = p_q;
    gs_d       = gs_q;
    gl_d       = gl_q;
    ps_d       = ps_q;
    pl_d       = pl_q;
    ns_d       = ns_q;
    nl_d       = nl_q;
    hp_d       = hp_q;
    hn_d       = hn_q;
    res_b_d    = res_b_q;
    res_s_d    = res_s_q;
    ob_d       = ob_q;
    os_d       = os_q;
    seg_we     = 1'b0;
    seg_wa     = '0;
    seg_wd     = '0;
    seg_ra     = k_q[SEG_IW-1:0];
    gnt_we     = 1'b0;
    gnt_wa     = req_m1[REQ_IW-1:0];
    gnt_wd     = {1'b0, gs_q, gl_q};
    gnt_ra     = req_m1[REQ_IW-1:0];

    case (cmd_i.op)
      DP_INIT: begin
        req_cnt_d = '0;
        seg_cnt_d = (mem_size_q != '0) ? SEG_CW'(1) : '0;
        seg_we    = mem_size_q != '0;
        seg_wd    = {A'(1), mem_size_q};
      end
      DP_START: begin
        op_d    = opcode_e'(req_opcode_i);
        len_d   = req_alloc_length_i;
        req_d   = req_request_number_i;
        num_d   = req_cnt_q[REQ_IW-1:0];
        k_d     = '0;
        rv_d    = 1'b0;
        hp_d    = 1'b0;
        hn_d    = 1'b0;
        res_b_d = '0;
        res_s_d = ST_FULL;
        gnt_ra  = in_req_m1[REQ_IW-1:0];
        if (!sts_o.req_full) begin
          req_cnt_d = req_cnt_q + 1'b1;
          gnt_we    = 1'b1;
          gnt_wa    = req_cnt_q[REQ_IW-1:0];
          gnt_wd    = '0;
        end
      end
      DP_SCAN_A: begin
        if (k_q < seg_cnt_q) begin
          k_d  = k_q + 1'b1;
          rv_d = 1'b1;
          ri_d = k_q;
        end else begin
          rv_d = 1'b0;
        end
        if (sts_o.a_hit) begin
          ns_d = rd_s;
          nl_d = rd_l;
          p_d  = ri_q;
        end
        if (sts_o.a_fail) begin
          res_s_d = ST_NOFIT;
        end
      end
      DP_ALLOC_FIN: begin
        gnt_we  = 1'b1;
        gnt_wa  = num_q;
        gnt_wd  = {1'b1, ns_q, len_q};
        res_b_d = ns_q;
        res_s_d = ST_GRANTED;
        if (sts_o.split) begin
          seg_we = 1'b1;
          seg_wa = p_q[SEG_IW-1:0];
          seg_wd = {A'(ns_q + len_q), A'(nl_q - len_q)};
        end else begin
          k_d  = p_q + 1'b1;
          rv_d = 1'b0;
        end
      end
      DP_SHIFT_DN: begin
        if (k_q < seg_cnt_q) begin
          k_d  = k_q + 1'b1;
          rv_d = 1'b1;
          ri_d = k_q;
        end else begin
          rv_d      = 1'b0;
          seg_cnt_d = seg_cnt_q - 1'b1;
        end
        if (rv_q) begin
          seg_we = 1'b1;
          seg_wa = ri_m1[SEG_IW-1:0];
          seg_wd = seg_rd;
        end
      end
      DP_SHIFT_UP: begin
        seg_ra = k_m1[SEG_IW-1:0];
        if (k_q > p_q) begin
          k_d  = k_m1;
          rv_d = 1'b1;
          ri_d = k_m1;
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          seg_we = 1'b1;
          seg_wa = ri_p1[SEG_IW-1:0];
          seg_wd = seg_rd;
        end
      end
      DP_INSERT: begin
        seg_we    = 1'b1;
        seg_wa    = p_q[SEG_IW-1:0];
        seg_wd    = {gs_q, gl_q};
        seg_cnt_d = seg_cnt_q + 1'b1;
        gnt_we    = 1'b1;
      end
      DP_GRANT: begin
        gs_d = gnt_rd[SEG_W-1:A];
        gl_d = gnt_rd[A-1:0];
      end
      DP_SCAN_F: begin
        if (!f_stop && (k_q < seg_cnt_q)) begin
          k_d  = k_q + 1'b1;
          rv_d = 1'b1;
          ri_d = k_q;
        end else begin
          rv_d = 1'b0;
        end
        if (f_stop) begin
          hn_d = 1'b1;
          ns_d = rd_s;
          nl_d = rd_l;
          p_d  = ri_q;
        end else begin
          if (rv_q) begin
            hp_d = 1'b1;
            ps_d = rd_s;
            pl_d = rd_l;
          end
          if (k_q >= seg_cnt_q) begin
            p_d = seg_cnt_q;
          end
        end
      end
      DP_MERGE: begin
        if (sts_o.join_prev && sts_o.join_next) begin
          seg_we = 1'b1;
          seg_wa = p_m1[SEG_IW-1:0];
          seg_wd = {ps_q, A'(pl_q + gl_q + nl_q)};
          gnt_we = 1'b1;
          k_d    = p_q + 1'b1;
          rv_d   = 1'b0;
        end else if (sts_o.join_prev) begin
          seg_we = 1'b1;
          seg_wa = p_m1[SEG_IW-1:0];
          seg_wd = {ps_q, A'(pl_q + gl_q)};
          gnt_we = 1'b1;
        end else if (sts_o.join_next) begin
          seg_we = 1'b1;
          seg_wa = p_q[SEG_IW-1:0];
          seg_wd = {gs_q, A'(nl_q + gl_q)};
          gnt_we = 1'b1;
        end else if (sts_o.seg_full) begin
          res_b_d = '0;
          res_s_d = ST_FULL;
        end else begin
          k_d  = seg_cnt_q;
          rv_d = 1'b0;
        end
      end
      DP_EMIT: begin
        ov_d = 1'b1;
        ob_d = res_b_q;
        os_d = res_s_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= A'(1048576);
      seg_cnt_q  <= '0;
      req_cnt_q  <= '0;
      rv_q       <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      mem_size_q <= mem_size_d;
      seg_cnt_q  <= seg_cnt_d;
      req_cnt_q  <= req_cnt_d;
      rv_q       <= rv_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    len_q   <= len_d;
    req_q   <= req_d;
    num_q   <= num_d;
    k_q     <= k_d;
    ri_q    <= ri_d;
    p_q     <= p_d;
    gs_q    <= gs_d;
    gl_q    <= gl_d;
    ps_q    <= ps_d;
    pl_q    <= pl_d;
    ns_q    <= ns_d;
    nl_q    <= nl_d;
    hp_q    <= hp_d;
    hn_q    <= hn_d;
    res_b_q <= res_b_d;
    res_s_q <= res_s_d;
    ob_q    <= ob_d;
    os_q    <= os_d;
  end

  assign cfg.ready       = 1'b1;
  assign rsp.valid       = ov_q;
  assign rsp.block_start = ob_q;
  assign rsp.status      = os_q;

  `FFA_ASSERT(a_seg_cnt_bound, seg_cnt_q <= SEG_CW'(MAX_SEGMENTS), "segment count overflow")
  `FFA_ASSERT(a_req_cnt_bound, req_cnt_q <= REQ_CW'(MAX_REQUESTS), "request count overflow")
  `FFA_ASSERT(a_emit_free, (cmd_i.op == DP_EMIT) |-> (!ov_q || rsp.ready), "result overwritten")

endmodule

// File: hdl/first_fit_allocator_unit.sv
// First-fit allocator over a linear region of cells numbered from 1.
// req_i carries one item: opcode (init, allocate, free), alloc_length and
// request_number. rsp_o returns block_start and status for an allocate, for a
// free that finds the segment table full, and for any allocate or free once the
// request count is used up. cfg_i writes memory_size; init reads it.
// Init returns nothing. An allocate scans the free-segment table through one
// RAM read port, one entry per cycle, and when a segment is used up it moves
// the later table entries down one place.
// A free takes a grant lookup, the same scan up to the freed address, then a
// merge write or an insert that shifts the table tail one entry per cycle.
// The scan up to the merge point and the shift of the tail together pass over
// the table once on the single segment RAM port.
// One item is in work at a time; req_i.ready is high only between items.
// A result waits in the output register while the next item is taken; the block
// holds in its response state when the receiver stalls and a new result is due.
// Reset empties the table and the request count; no region exists until init.
// memory_size resets to 1048576. No clearing pass is needed after reset.
module first_fit_allocator_unit import ffa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ffa_req_if.sink   req_i,
  ffa_rsp_if.source rsp_o,
  ffa_cfg_if.sink   cfg_i
);

  cmd_t cmd;
  sts_t sts;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffa_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .req_opcode_i         (req_i.opcode),
    .req_alloc_length_i   (req_i.alloc_length),
    .req_request_number_i (req_i.request_number),
    .cfg                  (cfg_i),
    .rsp                  (rsp_o)
  );

endmodule

// File: tb/ffa_alloc_checker.sv
`timescale 1ns / 100ps
module ffa_alloc_checker import ffa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ffa_req_if   req_i,
  ffa_rsp_if   rsp_i,
  ffa_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [ADDR_BITS-1:0] block_start;
    status_e              status;
  } grant_rsp_t;

  logic [ADDR_BITS-1:0] size_q;
  logic [ADDR_BITS-1:0] seg_base[MAX_SEGMENTS];
  logic [ADDR_BITS-1:0] seg_len[MAX_SEGMENTS];
  int                   seg_num;
  logic [ADDR_BITS-1:0] blk_base[MAX_REQUESTS];
  logic [ADDR_BITS-1:0] blk_len[MAX_REQUESTS];
  logic                 blk_live[MAX_REQUESTS];
  int                   req_cnt;
  grant_rsp_t           want_q[$];
  int                   fails;

  assign fail_count_o = fails;
  assign pending_o    = want_q.size();

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fails++;
  endtask

  function automatic void drop_seg(input int pos);
    for (int k = pos; k + 1 < seg_num; k++) begin
      seg_base[k] = seg_base[k+1];
      seg_len[k]  = seg_len[k+1];
    end
    seg_num--;
  endfunction

  function automatic bit free_block(input int rn);
    logic [ADDR_BITS-1:0] gs, gl;
    int p;
    bit jp, jn;
    if (rn == 0 || rn > req_cnt) return 0;
    if (!blk_live[rn-1]) return 0;
    gs = blk_base[rn-1];
    gl = blk_len[rn-1];
    p = 0;
    while (p < seg_num && seg_base[p] <= gs) p++;
    jp = p > 0 && ADDR_BITS'(seg_base[p-1] + seg_len[p-1]) == gs;
    jn = p < seg_num && ADDR_BITS'(gs + gl) == seg_base[p];
    if (jp && jn) begin
      seg_len[p-1] = seg_len[p-1] + gl + seg_len[p];
      drop_seg(p);
    end else if (jp) begin
      seg_len[p-1] = seg_len[p-1] + gl;
    end else if (jn) begin
      seg_base[p] = gs;
      seg_len[p]  = seg_len[p] + gl;
    end else begin
      if (seg_num >= MAX_SEGMENTS) return 1;
      for (int k = seg_num; k > p; k--) begin
        seg_base[k] = seg_base[k-1];
        seg_len[k]  = seg_len[k-1];
      end
      seg_base[p] = gs;
      seg_len[p]  = gl;
      seg_num++;
    end
    blk_live[rn-1] = 0;
    return 0;
  endfunction

  task automatic predict_item(input logic [OP_W-1:0] op, input logic [ADDR_BITS-1:0] len,
                              input logic [REQ_NUM_W-1:0] rn);
    int num, k;
    if (op == OP_INIT) begin
      foreach (blk_live[i]) blk_live[i] = 0;
      req_cnt = 0;
      seg_num = 0;
      if (size_q != 0) begin
        seg_base[0] = 1;
        seg_len[0]  = size_q;
        seg_num     = 1;
      end
      return;
    end
    if (op != OP_ALLOC && op != OP_FREE) return;
    if (req_cnt >= MAX_REQUESTS) begin
      want_q.push_back('{0, ST_FULL});
      return;
    end
    num = req_cnt;
    req_cnt++;
    blk_live[num] = 0;
    if (op == OP_ALLOC) begin
      for (k = 0; k < seg_num; k++)
        if (len != 0 && seg_len[k] >= len) break;
      if (len == 0 || k >= seg_num) begin
        want_q.push_back('{0, ST_NOFIT});
        return;
      end
      blk_base[num] = seg_base[k];
      blk_len[num]  = len;
      blk_live[num] = 1;
      want_q.push_back('{seg_base[k], ST_GRANTED});
      if (seg_len[k] > len) begin
        seg_base[k] = seg_base[k] + len;
        seg_len[k]  = seg_len[k] - len;
      end else begin
        drop_seg(k);
      end
    end else if (free_block(rn)) begin
      want_q.push_back('{0, ST_FULL});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_rsp_t w;
    if (!rst_ni) begin
      size_q  <= ADDR_BITS'(1048576);
      seg_num = 0;
      req_cnt = 0;
      foreach (blk_live[i]) blk_live[i] = 0;
      want_q.delete();
      fails   = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (want_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          w = want_q.pop_front();
          if (rsp_i.block_start !== w.block_start)
            report_mismatch($sformatf("block_start %0d want %0d", rsp_i.block_start,
                                      w.block_start));
          if (rsp_i.status !== w.status)
            report_mismatch($sformatf("status %0d want %0d", rsp_i.status, w.status));
        end
      end
      if (req_i.valid && req_i.ready)
        predict_item(req_i.opcode, req_i.alloc_length, req_i.request_number);
      if (cfg_i.valid && cfg_i.ready) size_q <= cfg_i.memory_size;
    end
  end

endmodule

// File: tb/first_fit_allocator_unit_test.sv
`timescale 1ns / 100ps
module first_fit_allocator_unit_test;
  import ffa_pkg::*;

  localparam int STALL_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  int   idle_cycles;
  bit   all_sent = 0;
  bit   hold_rsp = 0;
  int   issued = 0;

  ffa_req_if req_if ();
  ffa_rsp_if rsp_if ();
  ffa_cfg_if cfg_if ();

  always #5 clk_i = ~clk_i;

  first_fit_allocator_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source),
    .cfg_i  (cfg_if.sink)
  );

  ffa_alloc_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    req_if.valid = 0;
    req_if.opcode = OP_INIT;
    req_if.alloc_length = 0;
    req_if.request_number = 0;
    rsp_if.ready = 0;
    cfg_if.valid = 0;
    cfg_if.memory_size = 0;
  end

  task automatic send_item(input logic [1:0] op, input logic [ADDR_BITS-1:0] len,
                           input logic [REQ_NUM_W-1:0] rn, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      req_if.valid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1;
    req_if.opcode <= op;
    req_if.alloc_length <= len;
    req_if.request_number <= rn;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    issued++;
    @(negedge clk_i);
  endtask

  task automatic write_size(input logic [ADDR_BITS-1:0] sz);
    req_if.valid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (2 * MAX_SEGMENTS + 20) @(negedge clk_i);
    cfg_if.valid <= 1;
    cfg_if.memory_size <= sz;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 0;
  endtask

  task automatic random_phase(input int n, input logic [ADDR_BITS-1:0] sz);
    logic [ADDR_BITS-1:0] len;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(OP_INIT, ADDR_BITS'($urandom), REQ_NUM_W'($urandom), 1);
        issued = 0;
      end else if (r < 55) begin
        if ($urandom_range(0, 9) == 0) len = ADDR_BITS'($urandom);
        else len = ADDR_BITS'($urandom_range(1, (sz > 64) ? sz / 16 : sz));
        send_item(OP_ALLOC, len, REQ_NUM_W'($urandom), 1);
      end else if (r < 95) begin
        send_item(OP_FREE, ADDR_BITS'($urandom),
                  REQ_NUM_W'((issued > 0) ? $urandom_range(1, issued) : 1), 1);
      end else begin
        send_item($urandom_range(0, 3) == 0 ? 2'd3 : OP_FREE, ADDR_BITS'($urandom),
                  REQ_NUM_W'($urandom), 1);
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    // before any init
    send_item(OP_ALLOC, 5, 0, 0);
    send_item(OP_FREE, 0, 1, 0);
    send_item(OP_INIT, 0, 0, 0);
    send_item(OP_ALLOC, 21'h1FFFFF, 0, 0);
    send_item(OP_ALLOC, 21'h100000, 0, 0);
    send_item(OP_ALLOC, 0, 0, 0);
    send_item(OP_FREE, 0, 4, 0);
    send_item(OP_FREE, 0, 4, 0);
    send_item(OP_FREE, 0, 0, 0);
    send_item(OP_FREE, 0, 11'h7FF, 0);
    send_item(2'd3, 21'h1FFFFF, 11'h7FF, 0);
    write_size(10);
    send_item(OP_INIT, 0, 0, 0);
    send_item(OP_ALLOC, 3, 0, 0);
    send_item(OP_ALLOC, 3, 0, 0);
    send_item(OP_ALLOC, 3, 0, 0);
    send_item(OP_ALLOC, 2, 0, 0);
    send_item(OP_FREE, 0, 2, 0);
    send_item(OP_FREE, 0, 1, 0);
    send_item(OP_FREE, 0, 3, 0);
    send_item(OP_ALLOC, 10, 0, 0);
    write_size(0);
    send_item(OP_INIT, 0, 0, 0);
    send_item(OP_ALLOC, 1, 0, 0);
    write_size(1);
    send_item(OP_INIT, 0, 0, 0);
    send_item(OP_ALLOC, 1, 0, 0);
    write_size(200);
    send_item(OP_INIT, 0, 0, 0);
    issued = 0;
    random_phase(200, 200);
    write_size(21'h1FFFFF);
    send_item(OP_INIT, 0, 0, 0);
    issued = 0;
    random_phase(150, 21'h1FFFFF);
    write_size(1000);
    send_item(OP_INIT, 0, 0, 0);
    issued = 0;
    random_phase(200, 1000);
    req_if.valid <= 0;
    all_sent = 1;
  end

  initial begin
    int w;
    @(posedge rst_ni);
    @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    hold_rsp = 1;
    repeat (3000) @(negedge clk_i);
    hold_rsp = 0;
    forever begin
      w = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        rsp_if.ready <= 0;
        repeat (w) @(negedge clk_i);
      end
      while (hold_rsp) @(negedge clk_i);
      rsp_if.ready <= 1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    wait (all_sent);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * MAX_SEGMENTS + 20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/ffa_pkg.sv
hdl/ffa_req_if.sv
hdl/ffa_rsp_if.sv
hdl/ffa_cfg_if.sv
hdl/ffa_ram.sv
hdl/ffa_ctrl.sv
hdl/ffa_dp.sv
hdl/first_fit_allocator_unit.sv
tb/ffa_alloc_checker.sv
tb/first_fit_allocator_unit_test.sv
